>>> rtl/rmv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmv_pkg;

  // Sample input: only the low SAMPLE_BITS bits carry the value
  localparam int SAMPLE_W    = 32;
  localparam int SAMPLE_BITS = 32;
  localparam int SAMPLE_PAD  = SAMPLE_W - SAMPLE_BITS;

  localparam int FRAC_W  = 16;            // extra fraction bits of the mean accumulator
  localparam int CNT_W   = 32;
  localparam int MEAN_W  = 48;            // Q16.32
  localparam int SQ_W    = 64;
  localparam int VAR_W   = 48;
  localparam int SD_W    = 32;
  localparam int DIFF_W  = MEAN_W + 1;    // magnitude of a deviation
  localparam int INC_W   = DIFF_W + 1;    // product shifted down by 48
  localparam int QUO_W   = SQ_W;          // divider dividend / quotient width
  localparam int DIV_STEP_W = $clog2(QUO_W + 1);
  localparam int MUL_CNT_W  = $clog2(DIFF_W + 1);
  localparam int RAD_W      = VAR_W + FRAC_W;
  localparam int SQRT_CNT_W = $clog2(SD_W + 1);

  localparam int MIN_VALID_COUNT = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_MEAN,
    ST_DIFF2,
    ST_MUL,
    ST_ACCUM,
    ST_CHECK,
    ST_DIV_VAR,
    ST_SQRT,
    ST_OUT
  } rmv_state_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
  } div_cmd_t;

endpackage
`default_nettype wire

>>> rtl/rmv_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rmv_in_if import rmv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

>>> rtl/rmv_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rmv_out_if import rmv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CNT_W-1:0]         sample_count;
  logic signed [SAMPLE_W-1:0] running_mean;
  logic [VAR_W-1:0]         variance;
  logic [SD_W-1:0]          std_deviation;
  logic                     stats_valid;

  modport source (output valid, output sample_count, output running_mean,
                  output variance, output std_deviation, output stats_valid,
                  input ready);
  modport sink (input valid, input sample_count, input running_mean,
                input variance, input std_deviation, input stats_valid,
                output ready);
endinterface
`default_nettype wire

>>> rtl/rmv_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rmv_div import rmv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_cmd_t         cmd,
  input  logic [QUO_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  logic [CNT_W-1:0]      rem;
  logic [QUO_W-1:0]      dq;
  logic [DIV_STEP_W-1:0] left;
  logic                  busy;
  logic                  done_q;
  logic [CNT_W-1:0]      divisor_q;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             fits;
  logic [CNT_W-1:0] rem_next;

  // One restoring step per cycle; quotient bits shift in from the bottom of dq
  assign trial    = {rem, dq[QUO_W-1]};
  assign diff     = trial - {1'b0, divisor_q};
  assign fits     = (trial >= {1'b0, divisor_q});
  assign rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
      left   <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        left <= cmd.steps;
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == DIV_STEP_W'(1)) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem       <= '0;
      dq        <= dividend;
      divisor_q <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= {dq[QUO_W-2:0], fits};
    end
  end

  assign done     = done_q;
  assign quotient = dq;

endmodule
`default_nettype wire

>>> rtl/rmv_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module rmv_sqrt import rmv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RAD_W-1:0] radicand,
  output logic             done,
  output logic [SD_W-1:0]  root
);

  localparam int REM_W   = SD_W + 2;
  localparam int TRIAL_W = REM_W + 2;

  logic [RAD_W-1:0]      x;
  logic [REM_W-1:0]      rem;
  logic [SD_W-1:0]       root_q;
  logic [SQRT_CNT_W-1:0] left;
  logic                  busy;
  logic                  done_q;

  logic [TRIAL_W-1:0] trial;
  logic [TRIAL_W-1:0] test;
  logic [TRIAL_W-1:0] diff;
  logic               fits;

  // Bring down two radicand bits, try root*4+1
  assign trial = {rem, x[RAD_W-1 -: 2]};
  assign test  = {2'b00, root_q, 2'b01};
  assign diff  = trial - test;
  assign fits  = (trial >= test);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
      left   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        left <= SQRT_CNT_W'(SD_W);
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == SQRT_CNT_W'(1)) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x      <= radicand;
      rem    <= '0;
      root_q <= '0;
    end else if (busy) begin
      x      <= {x[RAD_W-3:0], 2'b00};
      rem    <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      root_q <= {root_q[SD_W-2:0], fits};
    end
  end

  assign done = done_q;
  assign root = root_q;

endmodule
`default_nettype wire

>>> rtl/running_mean_variance_core.sv
// Running mean and sample variance, Welford update, fixed point.
//
// samples: one signed Q16.16 sample per transfer (valid/ready).
// stats:   one result per sample: count, mean (Q16.16), sample variance
//          (unsigned, 16 fraction bits, saturating), standard deviation
//          (Q16.16) and stats_valid, high from the second sample on.
//
// Each sample runs through a bit-serial datapath: a restoring divider
// (49 steps for the mean update, 64 steps for m2/(n-1)), a shift-add
// multiplier for the deviation product (49 steps) and a digit-by-digit
// square root (32 steps). The divider is shared by both divisions.
// No variance is computed for the first sample. One sample is in work at a
// time; the next is taken once the previous result sits in the output
// register, so the block cannot take a new sample before it is through
// with the last one.
//
// Reset (rst, synchronous) clears count, mean and sum of squares, and
// empties the output register. A stalled receiver holds the result in the
// output register; the block still takes and works on one more sample and
// then waits in its final step until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module running_mean_variance_core import rmv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rmv_in_if.sink    samples,
  rmv_out_if.source stats
);

  rmv_state_t state, state_next;

  // Statistics state
  logic [CNT_W-1:0]         count;
  logic signed [MEAN_W-1:0] mean;
  logic [SQ_W-1:0]          sq;

  // Per-sample working registers
  logic signed [MEAN_W-1:0] big;
  logic                     d1_neg;
  logic [DIFF_W-1:0]        d1_mag;
  logic                     d2_neg;
  logic [DIFF_W-1:0]        acc_hi;
  logic [DIFF_W-1:0]        mplier;
  logic [MUL_CNT_W-1:0]     mul_left;
  logic [VAR_W-1:0]         var_reg;
  logic [SD_W-1:0]          sd_reg;

  // Output register
  logic                       out_valid;
  logic [CNT_W-1:0]           out_count;
  logic signed [SAMPLE_W-1:0] out_mean;
  logic [VAR_W-1:0]           out_var;
  logic [SD_W-1:0]            out_sd;
  logic                       out_stats_valid;

  // Control
  logic     in_take;
  logic     out_load;
  logic     out_free;
  logic     count_ge2;
  logic     mul_last;
  div_cmd_t div_cmd;
  logic     sqrt_start;

  // Arithmetic units: shared divider and square root
  logic [QUO_W-1:0] div_dividend;
  logic [CNT_W-1:0] div_divisor;
  logic             div_done;
  logic [QUO_W-1:0] div_quo;
  logic             sqrt_done;
  logic [SD_W-1:0]  sqrt_root;
  logic [VAR_W-1:0] var_sat;

  // Datapath helpers
  logic signed [SAMPLE_W-1:0] samp_ext;
  logic signed [DIFF_W-1:0]   diff_cur;
  logic [DIFF_W-1:0]          diff_mag;
  logic signed [DIFF_W:0]     step_s;
  logic signed [DIFF_W:0]     mean_wide;
  logic [DIFF_W-1:0]          addend;
  logic [DIFF_W:0]            mul_sum;
  logic [INC_W-1:0]           inc;
  logic [SQ_W:0]              sq_sum;
  logic [SQ_W-1:0]            sq_next;

  assign samp_ext  = (samples.sample <<< SAMPLE_PAD) >>> SAMPLE_PAD;
  assign count_ge2 = (count >= CNT_W'(MIN_VALID_COUNT));
  assign out_free  = !out_valid || stats.ready;
  assign mul_last  = (mul_left == MUL_CNT_W'(1));

  // Deviation of the held sample from the current mean
  assign diff_cur = DIFF_W'(big) - DIFF_W'(mean);
  assign diff_mag = diff_cur[DIFF_W-1] ? DIFF_W'(-diff_cur) : DIFF_W'(diff_cur);

  // Mean update from the divider quotient, sign restored
  assign step_s    = d1_neg ? -$signed({1'b0, div_quo[DIFF_W-1:0]})
                            :  $signed({1'b0, div_quo[DIFF_W-1:0]});
  assign mean_wide = (DIFF_W + 1)'(mean) + step_s;

  // Shift-add multiplier, one multiplier bit per cycle
  assign addend  = mplier[0] ? d1_mag : '0;
  assign mul_sum = {1'b0, acc_hi} + {1'b0, addend};
  assign inc     = {acc_hi, mplier[DIFF_W-1]};

  // Saturating add, or subtract floored at zero when the signs differ
  assign sq_sum = {1'b0, sq} + (SQ_W + 1)'(inc);
  always_comb begin
    if (d1_neg == d2_neg) begin
      sq_next = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
    end else begin
      sq_next = (sq > SQ_W'(inc)) ? (sq - SQ_W'(inc)) : '0;
    end
  end

  assign var_sat = (div_quo[QUO_W-1:VAR_W] != '0) ? '1 : div_quo[VAR_W-1:0];

  // Divider operands: mean update aligns the 49-bit deviation to the top
  assign div_dividend = (state == ST_PREP) ? {diff_mag, (QUO_W - DIFF_W)'(0)} : sq;
  assign div_divisor  = (state == ST_PREP) ? count : (count - 1'b1);

  rmv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  rmv_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({var_sat, FRAC_W'(0)}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (samples.valid) state_next = ST_PREP;
      ST_PREP:     state_next = ST_DIV_MEAN;
      ST_DIV_MEAN: if (div_done) state_next = ST_DIFF2;
      ST_DIFF2:    state_next = ST_MUL;
      ST_MUL:      if (mul_last) state_next = ST_ACCUM;
      ST_ACCUM:    state_next = ST_CHECK;
      ST_CHECK:    state_next = count_ge2 ? ST_DIV_VAR : ST_OUT;
      ST_DIV_VAR:  if (div_done) state_next = ST_SQRT;
      ST_SQRT:     if (sqrt_done) state_next = ST_OUT;
      ST_OUT:      if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_take       = 1'b0;
    out_load      = 1'b0;
    sqrt_start    = 1'b0;
    div_cmd.start = 1'b0;
    div_cmd.steps = DIV_STEP_W'(QUO_W);
    unique case (state)
      ST_IDLE: in_take = 1'b1;
      ST_PREP: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = DIV_STEP_W'(DIFF_W);
      end
      ST_CHECK:   div_cmd.start = count_ge2;
      ST_DIV_VAR: sqrt_start = div_done;
      ST_OUT:     out_load = out_free;
      default: begin
        in_take = 1'b0;
      end
    endcase
  end

  assign samples.ready = in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Statistics state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mean  <= '0;
      sq    <= '0;
    end else begin
      if (in_take && samples.valid && (count != '1)) begin
        count <= count + 1'b1;
      end
      if ((state == ST_DIV_MEAN) && div_done) begin
        mean <= mean_wide[MEAN_W-1:0];
      end
      if (state == ST_ACCUM) begin
        sq <= sq_next;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (in_take && samples.valid) begin
      big <= {samp_ext, FRAC_W'(0)};
    end
    if (state == ST_PREP) begin
      d1_neg <= diff_cur[DIFF_W-1];
      d1_mag <= diff_mag;
    end
    if (state == ST_DIFF2) begin
      d2_neg   <= diff_cur[DIFF_W-1];
      mplier   <= diff_mag;
      acc_hi   <= '0;
      mul_left <= MUL_CNT_W'(DIFF_W);
    end else if (state == ST_MUL) begin
      acc_hi   <= mul_sum[DIFF_W:1];
      mplier   <= {mul_sum[0], mplier[DIFF_W-1:1]};
      mul_left <= mul_left - 1'b1;
    end
    if ((state == ST_CHECK) && !count_ge2) begin
      var_reg <= '0;
      sd_reg  <= '0;
    end
    if ((state == ST_DIV_VAR) && div_done) begin
      var_reg <= var_sat;
    end
    if ((state == ST_SQRT) && sqrt_done) begin
      sd_reg <= sqrt_root;
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (stats.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count       <= count;
      out_mean        <= mean[MEAN_W-1:FRAC_W];
      out_var         <= var_reg;
      out_sd          <= sd_reg;
      out_stats_valid <= count_ge2;
    end
  end

  assign stats.valid         = out_valid;
  assign stats.sample_count  = out_count;
  assign stats.running_mean  = out_mean;
  assign stats.variance      = out_var;
  assign stats.std_deviation = out_sd;
  assign stats.stats_valid   = out_stats_valid;

  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_stats_valid == (out_count >= CNT_W'(MIN_VALID_COUNT))))
    else $error("stats_valid disagrees with sample count");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stats_valid) |-> ((out_var == '0) && (out_sd == '0)))
    else $error("variance or deviation nonzero below two samples");

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count >= $past(count)))
    else $error("sample count decreased");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> !samples.ready)
    else $error("second sample taken while one is in work");

endmodule
`default_nettype wire
